// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL files; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge out of reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dr2alu_pkg.sv =====
// ----------------------------------------------------------------------------
// dr2alu_pkg
// Operation codes for the dyadic Z[sqrt2] ALU.
// ----------------------------------------------------------------------------
package dr2alu_pkg;

    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_MUL = 3'd0,
        KIND_ADD = 3'd1,
        KIND_SUB = 3'd2,
        KIND_NEG = 3'd3,
        KIND_EQ  = 3'd4
    } kind_t;

endpackage

// ===== hdl/dr2alu_ifs.sv =====
// ----------------------------------------------------------------------------
// dr2alu_ifs
// Valid/ready channels of the dyadic Z[sqrt2] ALU: operand item and result item.
// ----------------------------------------------------------------------------
interface dr2alu_in_if
    import dr2alu_pkg::*;
#(
    parameter int COEF_BITS = 32,
    parameter int EXP_BITS  = 8
) ();
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic signed [COEF_BITS-1:0] a_int_part;
    logic signed [COEF_BITS-1:0] a_root_part;
    logic [EXP_BITS-1:0]         a_halvings;
    logic signed [COEF_BITS-1:0] b_int_part;
    logic signed [COEF_BITS-1:0] b_root_part;
    logic [EXP_BITS-1:0]         b_halvings;

    modport source (
        output valid, kind, a_int_part, a_root_part, a_halvings,
               b_int_part, b_root_part, b_halvings,
        input  ready
    );
    modport sink (
        input  valid, kind, a_int_part, a_root_part, a_halvings,
               b_int_part, b_root_part, b_halvings,
        output ready
    );
endinterface

interface dr2alu_out_if
#(
    parameter int COEF_BITS = 32,
    parameter int EXP_BITS  = 8
) ();
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] res_int_part;
    logic signed [COEF_BITS-1:0] res_root_part;
    logic [EXP_BITS-1:0]         res_halvings;
    logic                        is_equal;
    logic                        overflow;

    modport source (
        output valid, res_int_part, res_root_part, res_halvings, is_equal, overflow,
        input  ready
    );
    modport sink (
        input  valid, res_int_part, res_root_part, res_halvings, is_equal, overflow,
        output ready
    );
endinterface

// ===== hdl/dyadic_root2_ring_alu_core.sv =====
// ----------------------------------------------------------------------------
// dyadic_root2_ring_alu_core
// Exact multiply, add, subtract, negate and compare on (x + y*sqrt2)/2^k.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock unless a full pipeline waits on
// result.ready; each item passes every stage in order. There are five
// registers in line: input, multiply/align, wide sum, trailing-zero search,
// and shift and wrap. The multiply/align stage holds four COEF_BITS x COEF_BITS products;
// the sum, trailing-zero and shift stages work on 3*COEF_BITS+2 bit words.
// Each stage has its own valid bit, so bubbles close up and an item is taken
// while a finished result waits at the output; operand.ready drops only when
// all five stages are full and result.ready is low.
`include "assert_macros.svh"

module dyadic_root2_ring_alu_core
    import dr2alu_pkg::*;
#(
    parameter int COEF_BITS = 32,
    parameter int EXP_BITS  = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    dr2alu_in_if.sink    operand,
    dr2alu_out_if.source result
);

    localparam int C    = COEF_BITS;
    localparam int E    = EXP_BITS;
    localparam int DMAX = 2 * C;
    localparam int DW   = $clog2(DMAX + 1);
    localparam int DCW  = (E > DW) ? E : DW;
    localparam int SHW  = 3 * C + 1;
    localparam int WS   = 3 * C + 2;
    localparam int XW   = E + 1;
    localparam int TZW  = $clog2(WS + 1);
    localparam int SW   = (TZW > XW) ? TZW : XW;

    localparam logic signed [C-1:0] COEF_MIN = {1'b1, {(C-1){1'b0}}};

    // pipeline control
    logic v_in_reg, v_mul_reg, v_sum_reg, v_norm_reg, v_out_reg;
    logic en_in, en_mul, en_sum, en_norm, en_out;

    // input stage
    logic [KIND_W-1:0]   kind_in_reg;
    logic signed [C-1:0] ai_in_reg, ar_in_reg, bi_in_reg, br_in_reg;
    logic [E-1:0]        ea_in_reg, eb_in_reg;

    // multiply / align stage
    logic signed [2*C-1:0] p_ii_next, p_rr_next, p_ir_next, p_ri_next;
    logic signed [2*C-1:0] p_ii_reg, p_rr_reg, p_ir_reg, p_ri_reg;
    logic signed [C:0]     a_i_x, a_r_x, b_i_x, b_r_x, b_i_s, b_r_s;
    logic signed [C:0]     n_i_next, n_r_next, s_i, s_r;
    logic signed [C:0]     n_i_reg, n_r_reg;
    logic signed [SHW-1:0] s_i_sh_next, s_r_sh_next, s_i_sh_reg, s_r_sh_reg;
    logic                  a_ge, n_nz;
    logic [E-1:0]          d_raw, e_n, e_s, e_eff;
    logic [DCW-1:0]        d_ext, d_cap;
    logic [DW-1:0]         d_eff;
    logic [XW-1:0]         e_mul_next, e_mul_reg;
    logic                  is_mul_mul_reg, arith_next, arith_mul_reg;
    logic signed [C-1:0]   neg_i, neg_r;
    logic signed [C-1:0]   byp_int_next, byp_root_next, byp_int_mul_reg, byp_root_mul_reg;
    logic [E-1:0]          byp_exp_next, byp_exp_mul_reg;
    logic                  byp_eq_next, byp_ovf_next, byp_eq_mul_reg, byp_ovf_mul_reg;

    // sum stage
    logic signed [WS-1:0] si_next, sr_next, si_sum_reg, sr_sum_reg;
    logic [XW-1:0]        e_sum_reg;
    logic                 arith_sum_reg;
    logic signed [C-1:0]  byp_int_sum_reg, byp_root_sum_reg;
    logic [E-1:0]         byp_exp_sum_reg;
    logic                 byp_eq_sum_reg, byp_ovf_sum_reg;

    // normalize stage
    logic [TZW-1:0]       tz_i, tz_r;
    logic [SW-1:0]        t_lim;
    logic [XW-1:0]        t_norm_reg, e_norm_reg;
    logic signed [WS-1:0] si_norm_reg, sr_norm_reg;
    logic                 arith_norm_reg;
    logic signed [C-1:0]  byp_int_norm_reg, byp_root_norm_reg;
    logic [E-1:0]         byp_exp_norm_reg;
    logic                 byp_eq_norm_reg, byp_ovf_norm_reg;

    // output stage
    logic signed [WS-1:0] sh_i, sh_r;
    logic [XW-1:0]        e_fin;
    logic                 fit_i, fit_r;
    logic signed [C-1:0]  res_int_next, res_root_next, res_int_reg, res_root_reg;
    logic [E-1:0]         res_exp_next, res_exp_reg;
    logic                 res_eq_next, res_ovf_next, res_eq_reg, res_ovf_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign en_out  = !v_out_reg  || result.ready;
    assign en_norm = !v_norm_reg || en_out;
    assign en_sum  = !v_sum_reg  || en_norm;
    assign en_mul  = !v_mul_reg  || en_sum;
    assign en_in   = !v_in_reg   || en_mul;

    assign operand.ready = en_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_mul_reg  <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_norm_reg <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (en_in)
                v_in_reg <= operand.valid;
            if (en_mul)
                v_mul_reg <= v_in_reg;
            if (en_sum)
                v_sum_reg <= v_mul_reg;
            if (en_norm)
                v_norm_reg <= v_sum_reg;
            if (en_out)
                v_out_reg <= v_norm_reg;
        end
    end

    // ------------------------------------------------------------------
    // multiply / align
    // ------------------------------------------------------------------
    assign p_ii_next = ai_in_reg * bi_in_reg;
    assign p_rr_next = ar_in_reg * br_in_reg;
    assign p_ir_next = ai_in_reg * br_in_reg;
    assign p_ri_next = ar_in_reg * bi_in_reg;

    always_comb
    begin
        a_i_x = (C+1)'(ai_in_reg);
        a_r_x = (C+1)'(ar_in_reg);
        b_i_x = (C+1)'(bi_in_reg);
        b_r_x = (C+1)'(br_in_reg);
        b_i_s = (kind_in_reg == KIND_SUB) ? -b_i_x : b_i_x;
        b_r_s = (kind_in_reg == KIND_SUB) ? -b_r_x : b_r_x;

        // N keeps its exponent, S is shifted up to it
        a_ge = (ea_in_reg >= eb_in_reg);
        if (a_ge)
        begin
            n_i_next = a_i_x;
            n_r_next = a_r_x;
            s_i      = b_i_s;
            s_r      = b_r_s;
            d_raw    = ea_in_reg - eb_in_reg;
            e_n      = ea_in_reg;
            e_s      = eb_in_reg;
        end
        else
        begin
            n_i_next = b_i_s;
            n_r_next = b_r_s;
            s_i      = a_i_x;
            s_r      = a_r_x;
            d_raw    = eb_in_reg - ea_in_reg;
            e_n      = eb_in_reg;
            e_s      = ea_in_reg;
        end

        // zero N: result is S canonicalized on its own exponent;
        // otherwise shifts beyond 2*C leave every result bit unchanged
        n_nz  = (n_i_next != '0) || (n_r_next != '0);
        d_ext = DCW'(d_raw);
        d_cap = (d_ext > DCW'(DMAX)) ? DCW'(DMAX) : d_ext;
        d_eff = n_nz ? d_cap[DW-1:0] : '0;
        e_eff = n_nz ? e_n : e_s;

        s_i_sh_next = SHW'(s_i) <<< d_eff;
        s_r_sh_next = SHW'(s_r) <<< d_eff;

        e_mul_next = (kind_in_reg == KIND_MUL) ? (XW'(ea_in_reg) + XW'(eb_in_reg))
                                               : XW'(e_eff);
        arith_next = (kind_in_reg == KIND_MUL) || (kind_in_reg == KIND_ADD) ||
                     (kind_in_reg == KIND_SUB);

        neg_i         = -ai_in_reg;
        neg_r         = -ar_in_reg;
        byp_int_next  = '0;
        byp_root_next = '0;
        byp_exp_next  = '0;
        byp_eq_next   = 1'b0;
        byp_ovf_next  = 1'b0;
        case (kind_in_reg)
            KIND_NEG:
            begin
                byp_int_next  = neg_i;
                byp_root_next = neg_r;
                byp_exp_next  = ea_in_reg;
                byp_ovf_next  = (ai_in_reg == COEF_MIN) || (ar_in_reg == COEF_MIN);
            end
            KIND_EQ:
            begin
                byp_eq_next = (ai_in_reg == bi_in_reg) && (ar_in_reg == br_in_reg) &&
                              (ea_in_reg == eb_in_reg);
            end
            default:
            begin
                byp_eq_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // exact sums
    // ------------------------------------------------------------------
    always_comb
    begin
        if (is_mul_mul_reg)
        begin
            si_next = WS'(p_ii_reg) + (WS'(p_rr_reg) <<< 1);
            sr_next = WS'(p_ir_reg) + WS'(p_ri_reg);
        end
        else
        begin
            si_next = WS'(n_i_reg) + WS'(s_i_sh_reg);
            sr_next = WS'(n_r_reg) + WS'(s_r_sh_reg);
        end
    end

    // ------------------------------------------------------------------
    // trailing zeros; a zero coefficient puts no limit on the shift
    // ------------------------------------------------------------------
    always_comb
    begin
        tz_i = TZW'(WS);
        tz_r = TZW'(WS);
        for (int i = WS - 1; i >= 0; i--)
        begin
            if (si_sum_reg[i])
                tz_i = TZW'(i);
            if (sr_sum_reg[i])
                tz_r = TZW'(i);
        end
        t_lim = SW'(e_sum_reg);
        if ((si_sum_reg != '0) && (SW'(tz_i) < t_lim))
            t_lim = SW'(tz_i);
        if ((sr_sum_reg != '0) && (SW'(tz_r) < t_lim))
            t_lim = SW'(tz_r);
    end

    // ------------------------------------------------------------------
    // shift, range check, wrap
    // ------------------------------------------------------------------
    always_comb
    begin
        sh_i  = si_norm_reg >>> t_norm_reg;
        sh_r  = sr_norm_reg >>> t_norm_reg;
        e_fin = e_norm_reg - t_norm_reg;
        fit_i = (sh_i == WS'($signed(sh_i[C-1:0])));
        fit_r = (sh_r == WS'($signed(sh_r[C-1:0])));
        if (arith_norm_reg)
        begin
            res_int_next  = sh_i[C-1:0];
            res_root_next = sh_r[C-1:0];
            res_exp_next  = e_fin[E-1:0];
            res_eq_next   = 1'b0;
            res_ovf_next  = !fit_i || !fit_r || e_fin[XW-1];
        end
        else
        begin
            res_int_next  = byp_int_norm_reg;
            res_root_next = byp_root_norm_reg;
            res_exp_next  = byp_exp_norm_reg;
            res_eq_next   = byp_eq_norm_reg;
            res_ovf_next  = byp_ovf_norm_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en_in && operand.valid)
        begin
            kind_in_reg <= operand.kind;
            ai_in_reg   <= operand.a_int_part;
            ar_in_reg   <= operand.a_root_part;
            ea_in_reg   <= operand.a_halvings;
            bi_in_reg   <= operand.b_int_part;
            br_in_reg   <= operand.b_root_part;
            eb_in_reg   <= operand.b_halvings;
        end
        if (en_mul && v_in_reg)
        begin
            p_ii_reg         <= p_ii_next;
            p_rr_reg         <= p_rr_next;
            p_ir_reg         <= p_ir_next;
            p_ri_reg         <= p_ri_next;
            n_i_reg          <= n_i_next;
            n_r_reg          <= n_r_next;
            s_i_sh_reg       <= s_i_sh_next;
            s_r_sh_reg       <= s_r_sh_next;
            e_mul_reg        <= e_mul_next;
            is_mul_mul_reg   <= (kind_in_reg == KIND_MUL);
            arith_mul_reg    <= arith_next;
            byp_int_mul_reg  <= byp_int_next;
            byp_root_mul_reg <= byp_root_next;
            byp_exp_mul_reg  <= byp_exp_next;
            byp_eq_mul_reg   <= byp_eq_next;
            byp_ovf_mul_reg  <= byp_ovf_next;
        end
        if (en_sum && v_mul_reg)
        begin
            si_sum_reg       <= si_next;
            sr_sum_reg       <= sr_next;
            e_sum_reg        <= e_mul_reg;
            arith_sum_reg    <= arith_mul_reg;
            byp_int_sum_reg  <= byp_int_mul_reg;
            byp_root_sum_reg <= byp_root_mul_reg;
            byp_exp_sum_reg  <= byp_exp_mul_reg;
            byp_eq_sum_reg   <= byp_eq_mul_reg;
            byp_ovf_sum_reg  <= byp_ovf_mul_reg;
        end
        if (en_norm && v_sum_reg)
        begin
            si_norm_reg       <= si_sum_reg;
            sr_norm_reg       <= sr_sum_reg;
            t_norm_reg        <= t_lim[XW-1:0];
            e_norm_reg        <= e_sum_reg;
            arith_norm_reg    <= arith_sum_reg;
            byp_int_norm_reg  <= byp_int_sum_reg;
            byp_root_norm_reg <= byp_root_sum_reg;
            byp_exp_norm_reg  <= byp_exp_sum_reg;
            byp_eq_norm_reg   <= byp_eq_sum_reg;
            byp_ovf_norm_reg  <= byp_ovf_sum_reg;
        end
        if (en_out && v_norm_reg)
        begin
            res_int_reg  <= res_int_next;
            res_root_reg <= res_root_next;
            res_exp_reg  <= res_exp_next;
            res_eq_reg   <= res_eq_next;
            res_ovf_reg  <= res_ovf_next;
        end
    end

    assign result.valid         = v_out_reg;
    assign result.res_int_part  = res_int_reg;
    assign result.res_root_part = res_root_reg;
    assign result.res_halvings  = res_exp_reg;
    assign result.is_equal      = res_eq_reg;
    assign result.overflow      = res_ovf_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_eq_clean,
        (result.valid && result.is_equal) |-> (result.res_int_part == '0 &&
            result.res_root_part == '0 && result.res_halvings == '0 && !result.overflow),
        "equality item carries arithmetic fields")
    `ASSERT_CLK(a_full_stall,
        !operand.ready |-> (v_in_reg && v_mul_reg && v_sum_reg && v_norm_reg &&
            v_out_reg && !result.ready),
        "input stalled with a free stage")
    `ASSERT_CLK(a_shift_bound, v_norm_reg |-> (t_norm_reg <= e_norm_reg),
        "normalize shift exceeds exponent")
    `ASSERT_NEXT(a_out_load, v_norm_reg && en_out, result.valid,
        "normalized item not moved to output")

endmodule

// ===== sim/tb_dyadic_root2_ring_alu_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dyadic_root2_ring_alu_core
// Self-checking bench for the dyadic Z[sqrt2] ALU. A directed set covers the
// field extremes, every operation and the wrap, zero and unused-kind cases;
// random items follow. Expected results come from an exact wide-integer
// predictor and are checked in order against every result item. Both
// channels idle in random bursts, and one long result stall backs up the
// pipeline.
// ----------------------------------------------------------------------------
module tb_dyadic_root2_ring_alu_core;
    import dr2alu_pkg::*;

    localparam int COEF_BITS  = 32;
    localparam int EXP_BITS   = 8;
    localparam int WIDE_BITS  = 320;
    localparam int N_RANDOM   = 430;
    localparam int QUIET_TAIL = 60;
    localparam int STALL_LEN  = 80;
    localparam int IDLE_LIMIT = 4000;

    localparam logic signed [COEF_BITS-1:0] C_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] C_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [EXP_BITS-1:0]         H_MAX = {EXP_BITS{1'b1}};

    typedef logic signed [WIDE_BITS-1:0] wide_t;

    typedef struct {
        logic [KIND_W-1:0]           kind;
        logic signed [COEF_BITS-1:0] a_int_part;
        logic signed [COEF_BITS-1:0] a_root_part;
        logic [EXP_BITS-1:0]         a_halvings;
        logic signed [COEF_BITS-1:0] b_int_part;
        logic signed [COEF_BITS-1:0] b_root_part;
        logic [EXP_BITS-1:0]         b_halvings;
    } operands_t;

    typedef struct {
        logic signed [COEF_BITS-1:0] res_int_part;
        logic signed [COEF_BITS-1:0] res_root_part;
        logic [EXP_BITS-1:0]         res_halvings;
        logic                        is_equal;
        logic                        overflow;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    dr2alu_in_if  #(.COEF_BITS(COEF_BITS), .EXP_BITS(EXP_BITS)) operand_ch ();
    dr2alu_out_if #(.COEF_BITS(COEF_BITS), .EXP_BITS(EXP_BITS)) result_ch ();

    dyadic_root2_ring_alu_core #(
        .COEF_BITS (COEF_BITS),
        .EXP_BITS  (EXP_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .result  (result_ch)
    );

    operands_t pending_ops[$];
    outcome_t  expected_results[$];
    operands_t drv_item;
    outcome_t  want;
    int        gap_left;
    int        hold_left;
    int        n_sent;
    int        n_results;
    int        n_fail;
    int        idle_cycles;
    bit        long_stall_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // no random idling once fewer than QUIET_TAIL items wait to be sent
    function automatic bit quiet();
        return (pending_ops.size() < QUIET_TAIL);
    endfunction

    // exact value of one operation, wrapped to the result fields
    function automatic outcome_t dyadic_result(operands_t o);
        wide_t       ai, ar, bi, br, si, sr, fit_i, fit_r;
        int unsigned ea, eb, e;
        bit          canon;
        outcome_t    r;
        r = '{default: '0};
        ai = o.a_int_part;
        ar = o.a_root_part;
        bi = o.b_int_part;
        br = o.b_root_part;
        ea = o.a_halvings;
        eb = o.b_halvings;
        canon = 1'b0;
        si = '0;
        sr = '0;
        e = 0;
        case (o.kind)
            KIND_MUL:
            begin
                si = ai * bi + ((ar * br) <<< 1);
                sr = ai * br + ar * bi;
                e = ea + eb;
                canon = 1'b1;
            end
            KIND_ADD, KIND_SUB:
            begin
                if (o.kind == KIND_SUB)
                begin
                    bi = -bi;
                    br = -br;
                end
                e = (ea > eb) ? ea : eb;
                si = (ai <<< (e - ea)) + (bi <<< (e - eb));
                sr = (ar <<< (e - ea)) + (br <<< (e - eb));
                canon = 1'b1;
            end
            KIND_NEG:
            begin
                r.res_int_part  = -o.a_int_part;
                r.res_root_part = -o.a_root_part;
                r.res_halvings  = o.a_halvings;
                r.overflow      = (o.a_int_part == C_MIN) || (o.a_root_part == C_MIN);
            end
            KIND_EQ:
            begin
                r.is_equal = (o.a_int_part == o.b_int_part) &&
                             (o.a_root_part == o.b_root_part) &&
                             (o.a_halvings == o.b_halvings);
            end
            default:
            begin
            end
        endcase
        if (canon)
        begin
            while (e > 0 && si[0] == 1'b0 && sr[0] == 1'b0)
            begin
                si = si >>> 1;
                sr = sr >>> 1;
                e--;
            end
            fit_i = $signed(si[COEF_BITS-1:0]);
            fit_r = $signed(sr[COEF_BITS-1:0]);
            r.res_int_part  = si[COEF_BITS-1:0];
            r.res_root_part = sr[COEF_BITS-1:0];
            r.res_halvings  = e[EXP_BITS-1:0];
            r.overflow      = (fit_i != si) || (fit_r != sr) || (e > H_MAX);
        end
        return r;
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 32) - 16;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            2: return $urandom << $urandom_range(1, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [EXP_BITS-1:0] rand_halv();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return H_MAX;
            2: return $urandom_range(0, 8);
            default: return $urandom_range(0, H_MAX);
        endcase
    endfunction

    function automatic operands_t rand_operands();
        operands_t o;
        int        idx;
        o.kind        = $urandom_range(0, 19) / 4;
        if ($urandom_range(0, 29) == 0)
            o.kind = $urandom_range(5, 7);
        o.a_int_part  = rand_coef();
        o.a_root_part = rand_coef();
        o.a_halvings  = rand_halv();
        o.b_int_part  = rand_coef();
        o.b_root_part = rand_coef();
        o.b_halvings  = rand_halv();
        // equality and subtraction want mostly matching or near-matching operands
        if ((o.kind == KIND_EQ || o.kind == KIND_SUB) && $urandom_range(0, 2) != 0)
        begin
            o.b_int_part  = o.a_int_part;
            o.b_root_part = o.a_root_part;
            o.b_halvings  = o.a_halvings;
            case ($urandom_range(0, 5))
                0:
                begin
                    idx = $urandom_range(0, COEF_BITS-1);
                    o.b_int_part[idx] = ~o.b_int_part[idx];
                end
                1:
                begin
                    idx = $urandom_range(0, COEF_BITS-1);
                    o.b_root_part[idx] = ~o.b_root_part[idx];
                end
                2:
                begin
                    idx = $urandom_range(0, EXP_BITS-1);
                    o.b_halvings[idx] = ~o.b_halvings[idx];
                end
                default:
                begin
                end
            endcase
        end
        return o;
    endfunction

    task automatic push_op(input logic [KIND_W-1:0] k,
                           input logic signed [COEF_BITS-1:0] ai, ar,
                           input logic [EXP_BITS-1:0] ea,
                           input logic signed [COEF_BITS-1:0] bi, br,
                           input logic [EXP_BITS-1:0] eb);
        operands_t o;
        o = '{k, ai, ar, ea, bi, br, eb};
        pending_ops.push_back(o);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            operand_ch.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (operand_ch.valid && operand_ch.ready)
            begin
                expected_results.push_back(dyadic_result(drv_item));
                n_sent++;
            end
            if (!operand_ch.valid || operand_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    operand_ch.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_ops.size() > 0)
                begin
                    drv_item = pending_ops.pop_front();
                    operand_ch.valid       <= 1'b1;
                    operand_ch.kind        <= drv_item.kind;
                    operand_ch.a_int_part  <= drv_item.a_int_part;
                    operand_ch.a_root_part <= drv_item.a_root_part;
                    operand_ch.a_halvings  <= drv_item.a_halvings;
                    operand_ch.b_int_part  <= drv_item.b_int_part;
                    operand_ch.b_root_part <= drv_item.b_root_part;
                    operand_ch.b_halvings  <= drv_item.b_halvings;
                    if (!quiet() && (n_sent / 64) % 3 != 2 && $urandom_range(0, 4) == 0)
                        gap_left <= $urandom_range(1, 12);
                end
                else
                begin
                    operand_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $error("result item with no pending expectation");
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.res_int_part !== want.res_int_part)
                    begin
                        $error("res_int_part: expected %0d, got %0d",
                               want.res_int_part, result_ch.res_int_part);
                        n_fail++;
                    end
                    if (result_ch.res_root_part !== want.res_root_part)
                    begin
                        $error("res_root_part: expected %0d, got %0d",
                               want.res_root_part, result_ch.res_root_part);
                        n_fail++;
                    end
                    if (result_ch.res_halvings !== want.res_halvings)
                    begin
                        $error("res_halvings: expected %0d, got %0d",
                               want.res_halvings, result_ch.res_halvings);
                        n_fail++;
                    end
                    if (result_ch.is_equal !== want.is_equal)
                    begin
                        $error("is_equal: expected %0b, got %0b",
                               want.is_equal, result_ch.is_equal);
                        n_fail++;
                    end
                    if (result_ch.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, result_ch.overflow);
                        n_fail++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!long_stall_done && n_results >= 120)
            begin
                // long stall: pipeline fills and operand.ready must drop
                long_stall_done = 1'b1;
                result_ch.ready <= 1'b0;
                hold_left <= STALL_LEN - 1;
            end
            else if (!quiet() && (n_results / 64) % 3 != 1 && $urandom_range(0, 6) == 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left <= $urandom_range(0, 11);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((operand_ch.valid && operand_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        operand_ch.valid       = 1'b0;
        operand_ch.kind        = '0;
        operand_ch.a_int_part  = '0;
        operand_ch.a_root_part = '0;
        operand_ch.a_halvings  = '0;
        operand_ch.b_int_part  = '0;
        operand_ch.b_root_part = '0;
        operand_ch.b_halvings  = '0;
        result_ch.ready        = 1'b0;
        gap_left = 0;
        hold_left = 0;
        n_sent = 0;
        n_results = 0;
        n_fail = 0;
        idle_cycles = 0;
        long_stall_done = 1'b0;

        push_op(KIND_MUL, 3, 1, 0, 5, 2, 0);
        push_op(KIND_MUL, C_MAX, C_MAX, H_MAX, C_MAX, C_MAX, H_MAX);
        push_op(KIND_MUL, C_MIN, C_MIN, 0, C_MIN, C_MIN, 0);
        push_op(KIND_MUL, 4, 2, 3, 2, 0, 1);
        push_op(KIND_MUL, 0, 0, 7, 5, 3, 9);
        push_op(KIND_MUL, C_MIN, 0, 128, -1, 0, 128);
        push_op(KIND_ADD, 1, 1, 0, 1, 1, H_MAX);
        push_op(KIND_ADD, 1, 1, 3, 1, -1, 3);
        push_op(KIND_ADD, C_MAX, C_MAX, 0, C_MAX, C_MAX, 0);
        push_op(KIND_ADD, 5, -3, 4, -5, 3, 4);
        push_op(KIND_ADD, C_MIN, -1, H_MAX, C_MIN, 1, 0);
        push_op(KIND_SUB, 0, 0, 0, C_MIN, C_MIN, 0);
        push_op(KIND_SUB, 7, 2, 2, 3, 2, 5);
        push_op(KIND_SUB, 9, 9, 200, 9, 9, 200);
        push_op(KIND_NEG, C_MIN, 5, 6, 0, 0, 0);
        push_op(KIND_NEG, 0, C_MIN, H_MAX, 1, 1, 1);
        push_op(KIND_NEG, C_MAX, -1, 0, 0, 0, 0);
        push_op(KIND_NEG, 0, 0, 0, 0, 0, 0);
        push_op(KIND_EQ, C_MAX, C_MIN, H_MAX, C_MAX, C_MIN, H_MAX);
        push_op(KIND_EQ, 12, -7, 3, 12, -7, 4);
        push_op(KIND_EQ, 12, -7, 3, 12, 7, 3);
        push_op(KIND_EQ, 0, 0, 0, 0, 0, 0);
        push_op(3'd5, 11, 22, 33, 44, 55, 66);
        push_op(3'd6, C_MIN, C_MAX, H_MAX, -1, 1, 0);
        push_op(3'd7, -1, -1, H_MAX, -1, -1, H_MAX);
        repeat (N_RANDOM)
            pending_ops.push_back(rand_operands());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && operand_ch.valid == 1'b0);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
